### hw/rtl/vcfp_pkg.sv
// ----------------------------------------------------------------------------
// vcfp_pkg
// Shared types, byte codes and helpers for the VCF record field parser.
// ----------------------------------------------------------------------------
package vcfp_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam int FIELD_W   = 11;
  localparam int SAMPLE_W  = 10;

  // byte codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // column numbers
  localparam logic [FIELD_W-1:0] COL_CHROM  = 11'd0;
  localparam logic [FIELD_W-1:0] COL_POS    = 11'd1;
  localparam logic [FIELD_W-1:0] COL_REF    = 11'd3;
  localparam logic [FIELD_W-1:0] COL_ALT    = 11'd4;
  localparam logic [FIELD_W-1:0] COL_QUAL   = 11'd5;
  localparam logic [FIELD_W-1:0] COL_FILTER = 11'd6;
  localparam logic [FIELD_W-1:0] GENO_BASE  = 11'd9;
  localparam logic [FIELD_W-1:0] FIELD_MAX  = 11'd2047;

  // FILTER match progress
  localparam logic [3:0] PASS_DONE = 4'd4;
  localparam logic [3:0] PASS_FAIL = 4'd15;

  // output kinds
  localparam logic [1:0] KIND_CHROM  = 2'd0;
  localparam logic [1:0] KIND_REF    = 2'd1;
  localparam logic [1:0] KIND_ALT    = 2'd2;
  localparam logic [1:0] KIND_RECORD = 2'd3;

  // register map
  localparam logic REG_SAMPLE_COLUMN = 1'b0;

  typedef enum logic [3:0] {
    OP_CHROM,
    OP_REF,
    OP_ALT,
    OP_POS,
    OP_QUAL,
    OP_FILT,
    OP_GENO,
    OP_TAB,
    OP_EOL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] pass_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h50; // P
      2'd1:    ch = 8'h41; // A
      default: ch = 8'h53; // S
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // one decimal digit into an 8-bit value, saturating at 255
  function automatic logic [7:0] digit_step8(input logic [7:0] v, input logic [7:0] c);
    logic [11:0] prod;
    prod = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {4'd0, c - CH_ZERO};
    return (|prod[11:8]) ? 8'hFF : prod[7:0];
  endfunction

endpackage

### hw/rtl/vcfp_front.sv
// ----------------------------------------------------------------------------
// vcfp_front
// Line and column tracking; turns data-line bytes into back-end commands, except bytes of unused columns.
// ----------------------------------------------------------------------------
module vcfp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [vcfp_pkg::SAMPLE_W-1:0]  sample_column,
  input  logic                           in_valid,
  input  logic [7:0]                     in_data,
  output logic                           in_ready,
  output logic                           push_valid,
  output vcfp_pkg::cmd_t                 push_cmd,
  input  logic                           push_ready
);
  import vcfp_pkg::*;

  logic               header_line;
  logic               line_start;
  logic [FIELD_W-1:0] field_number;
  logic [FIELD_W-1:0] geno_col;
  logic               accept;
  logic               has_cmd;
  op_t                op;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign geno_col = FIELD_W'(sample_column) + GENO_BASE;

  always_comb begin
    has_cmd = 1'b0;
    op      = OP_TAB;
    if (!header_line && !(line_start && in_data == CH_HASH)) begin
      if (in_data == CH_LF) begin
        has_cmd = 1'b1;
        op      = OP_EOL;
      end else if (in_data == CH_TAB) begin
        has_cmd = 1'b1;
        op      = OP_TAB;
      end else begin
        has_cmd = 1'b1;
        if (field_number == COL_CHROM) begin
          op = OP_CHROM;
        end else if (field_number == COL_POS) begin
          op = OP_POS;
        end else if (field_number == COL_REF) begin
          op = OP_REF;
        end else if (field_number == COL_ALT) begin
          op = OP_ALT;
        end else if (field_number == COL_QUAL) begin
          op = OP_QUAL;
        end else if (field_number == COL_FILTER) begin
          op = OP_FILT;
        end else if (field_number == geno_col) begin
          op = OP_GENO;
        end else begin
          has_cmd = 1'b0;
        end
      end
    end
  end

  assign push_valid    = in_valid && has_cmd;
  assign push_cmd.op   = op;
  assign push_cmd.data = in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_line  <= 1'b0;
      line_start   <= 1'b1;
      field_number <= '0;
    end else if (accept) begin
      if (header_line) begin
        if (in_data == CH_LF) begin
          header_line <= 1'b0;
          line_start  <= 1'b1;
        end
      end else if (line_start && in_data == CH_HASH) begin
        header_line <= 1'b1;
        line_start  <= 1'b0;
      end else if (in_data == CH_LF) begin
        line_start   <= 1'b1;
        field_number <= '0;
      end else begin
        line_start <= 1'b0;
        if (in_data == CH_TAB && field_number != FIELD_MAX) begin
          field_number <= field_number + 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/vcfp_queue.sv
// ----------------------------------------------------------------------------
// vcfp_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module vcfp_queue #(
  parameter int DEPTH = vcfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  vcfp_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output vcfp_pkg::cmd_t pop_cmd,
  input  logic           pop_ready
);
  import vcfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not shrink on pop");
`endif

endmodule

### hw/rtl/vcfp_back.sv
// ----------------------------------------------------------------------------
// vcfp_back
// Executes commands: column accumulators, echo results and line records.
// ----------------------------------------------------------------------------
module vcfp_back #(
  parameter int POSITION_WIDTH = vcfp_pkg::POSITION_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  vcfp_pkg::cmd_t cmd,
  output logic           cmd_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     kind,
  output logic [7:0]     text_out,
  output logic [31:0]    position,
  output logic [7:0]     quality,
  output logic           passed,
  output logic [7:0]     allele_first,
  output logic [7:0]     allele_second
);
  import vcfp_pkg::*;

  localparam int PW   = POSITION_WIDTH;
  localparam int OW   = (PW > 32) ? PW : 32;

  logic [PW-1:0] position_accum;
  logic [7:0]    quality_accum;
  logic          digits_ended;
  logic [3:0]    pass_progress;
  logic [7:0]    first_allele_reg;
  logic [7:0]    second_allele_reg;

  logic          emits;
  logic          take;
  logic          digit;
  logic [PW+3:0] pos_prod;
  logic [PW-1:0] pos_step;
  logic [OW-1:0] pos_ext;
  logic [31:0]   pos_clamped;

  always_comb begin
    case (cmd.op)
      OP_CHROM, OP_REF, OP_ALT, OP_EOL: emits = 1'b1;
      default:                          emits = 1'b0;
    endcase
  end

  assign cmd_ready = !emits || !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign digit     = is_digit(cmd.data);

  // v*10 + d with saturation at all ones
  assign pos_prod = ((PW+4)'(position_accum) << 3) + ((PW+4)'(position_accum) << 1)
                  + (PW+4)'(cmd.data - CH_ZERO);
  assign pos_step = (|pos_prod[PW+3:PW]) ? '1 : pos_prod[PW-1:0];

  assign pos_ext     = OW'(position_accum);
  assign pos_clamped = (|(pos_ext >> 32)) ? 32'hFFFF_FFFF : pos_ext[31:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emits) begin
      if (cmd.op == OP_EOL) begin
        kind          <= KIND_RECORD;
        text_out      <= '0;
        position      <= pos_clamped;
        quality       <= quality_accum;
        passed        <= (pass_progress == PASS_DONE);
        allele_first  <= first_allele_reg;
        allele_second <= second_allele_reg;
      end else begin
        kind          <= (cmd.op == OP_CHROM) ? KIND_CHROM :
                         (cmd.op == OP_REF)   ? KIND_REF : KIND_ALT;
        text_out      <= cmd.data;
        position      <= '0;
        quality       <= '0;
        passed        <= 1'b0;
        allele_first  <= '0;
        allele_second <= '0;
      end
    end
  end

  // per-line accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      position_accum    <= '0;
      quality_accum     <= '0;
      digits_ended      <= 1'b0;
      pass_progress     <= '0;
      first_allele_reg  <= '0;
      second_allele_reg <= '0;
    end else if (take) begin
      unique case (cmd.op)
        OP_EOL: begin
          position_accum    <= '0;
          quality_accum     <= '0;
          digits_ended      <= 1'b0;
          pass_progress     <= '0;
          first_allele_reg  <= '0;
          second_allele_reg <= '0;
        end
        OP_TAB: begin
          digits_ended <= 1'b0;
        end
        OP_POS: begin
          if (!digits_ended) begin
            if (digit) position_accum <= pos_step;
            else       digits_ended   <= 1'b1;
          end
        end
        OP_QUAL: begin
          if (!digits_ended) begin
            if (digit) quality_accum <= digit_step8(quality_accum, cmd.data);
            else       digits_ended  <= 1'b1;
          end
        end
        OP_FILT: begin
          if (pass_progress < PASS_DONE && cmd.data == pass_char(pass_progress[1:0])) begin
            pass_progress <= pass_progress + 1'b1;
          end else begin
            pass_progress <= PASS_FAIL;
          end
        end
        OP_GENO: begin
          if (cmd.data == CH_SLASH || cmd.data == CH_PIPE) begin
            first_allele_reg  <= second_allele_reg;
            second_allele_reg <= '0;
            digits_ended      <= 1'b0;
          end else if (!digits_ended) begin
            if (digit) second_allele_reg <= digit_step8(second_allele_reg, cmd.data);
            else       digits_ended      <= 1'b1;
          end
        end
        OP_CHROM, OP_REF, OP_ALT: begin
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_echo_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_RECORD) |->
      (position == '0 && quality == '0 && !passed && allele_first == '0 &&
       allele_second == '0))
    else $error("echo result carries record fields");
  a_record_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_RECORD) |-> (text_out == '0))
    else $error("record carries echo byte");
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (take && cmd.op == OP_EOL) |=>
      (position_accum == '0 && pass_progress == '0 && !digits_ended))
    else $error("line state not cleared after newline");
`endif

endmodule

### hw/rtl/vcf_record_field_parser.sv
// ----------------------------------------------------------------------------
// vcf_record_field_parser
// Streams VCF text one byte a transfer; echoes CHROM/REF/ALT bytes and emits
// one record (POS, QUAL, FILTER==PASS, genotype) per data line.
// ----------------------------------------------------------------------------
//
//  channel  direction  signals                           content
//  s_*      in         s_tvalid s_tready s_tdata[7:0]     one text byte
//  m_*      out        m_tvalid m_tready m_tdata m_tuser  echo byte or record
//  apb      in/out     psel penable pwrite paddr pwdata   sample_column reg
//
//  Cycles: one byte per clock while m_tready keeps up. Front end classifies
//  a byte in the cycle it is taken; the back end executes one command per
//  clock unless its result is held; queue entries feed the result register.
//  Reset: synchronous rst clears line tracking, accumulators, queue and
//  the result valid flag; sample_column resets to 0.
//  Stalls: a stalled m_tready backs up the command queue; s_tready falls
//  only once the queue is full. Bytes that make no command (header lines,
//  unused columns) pass through the front end without using the queue.
//
module vcf_record_field_parser #(
  parameter int POSITION_WIDTH = vcfp_pkg::POSITION_WIDTH_DEF,
  parameter int QUEUE_DEPTH    = vcfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_in
  // results out
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] text_out, [39:8] position, [47:40] quality, [48] passed,
  // [56:49] allele_first, [64:57] allele_second, [71:65] zero
  output logic [71:0] m_tdata,
  output logic [1:0]  m_tuser,   // [1:0] kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vcfp_pkg::*;

  logic [SAMPLE_W-1:0] sample_column;
  logic                reg_index;

  logic  push_valid, push_ready;
  cmd_t  push_cmd;
  logic  pop_valid, pop_ready;
  cmd_t  pop_cmd;

  logic [7:0]  text_out;
  logic [31:0] position;
  logic [7:0]  quality;
  logic        passed;
  logic [7:0]  allele_first;
  logic [7:0]  allele_second;

  // register file: byte address 4*i, one register
  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_column <= '0;
    end else if (psel && penable && pwrite && pready && reg_index == REG_SAMPLE_COLUMN) begin
      sample_column <= pwdata[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    case (reg_index)
      REG_SAMPLE_COLUMN: prdata = 32'(sample_column);
      default:           prdata = '0;
    endcase
  end

  vcfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_column (sample_column),
    .in_valid      (s_tvalid),
    .in_data       (s_tdata),
    .in_ready      (s_tready),
    .push_valid    (push_valid),
    .push_cmd      (push_cmd),
    .push_ready    (push_ready)
  );

  vcfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  vcfp_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (pop_valid),
    .cmd           (pop_cmd),
    .cmd_ready     (pop_ready),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .kind          (m_tuser),
    .text_out      (text_out),
    .position      (position),
    .quality       (quality),
    .passed        (passed),
    .allele_first  (allele_first),
    .allele_second (allele_second)
  );

  assign m_tdata = {7'd0, allele_second, allele_first, passed, quality, position, text_out};

endmodule
